// File: rtl/dtdp_pkg.sv
package dtdp_pkg;

  // Default channel capacity of the packer
  localparam int MAX_CHANNELS_DEF = 8;

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 24;
  localparam int CHAN_OUT_W = 3;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 2;

  // Register reset value (both channel counts)
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd2;

  // DoP markers
  localparam logic [BYTE_W-1:0] MARKER_EVEN = 8'h05;
  localparam logic [BYTE_W-1:0] MARKER_ODD  = 8'hFA;

  // Depth of the internal queues
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_CHANNELS  = 2'd0,
    CFG_OUTPUT_CHANNELS = 2'd1
  } cfg_reg_e;

  // One finished DoP result
  typedef struct packed {
    logic [WORD_W-1:0]     dop_word;
    logic [CHAN_OUT_W-1:0] channel;
    logic                  frame_end;
  } dop_result_t;

endpackage

// File: rtl/dtdp_fifo.sv
module dtdp_fifo
  import dtdp_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: rtl/dtdp_front.sv
module dtdp_front
  import dtdp_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  parameter int ITEM_W       = CH_W + BYTE_W + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 clear_o,
  // byte stream in
  input  logic                 push_i,
  input  logic [BYTE_W-1:0]    dsd_byte_i,
  output logic                 full_o,
  // classified items out: {second_half, frame_end, channel, byte}
  output logic                 item_push_o,
  output logic [ITEM_W-1:0]    item_o,
  input  logic                 item_full_i
);

  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

  logic [CFG_W-1:0] in_cfg_q, out_cfg_q;
  logic [CH_W-1:0]  pos_q, pos_d;
  logic             half_q, half_d;
  logic [CNT_W-1:0] n_in, n_out, kept;
  logic [CNT_W:0]   pos_next;
  logic             accept, keep_ch, frame_end;

  // clamp a raw count register into 1..MAX_CHANNELS
  function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] r);
    logic [CNT_W-1:0] c;
    if (r == '0) begin
      c = CNT_W'(1);
    end else if (32'(r) > MAX_CHANNELS) begin
      c = CNT_W'(MAX_CHANNELS);
    end else begin
      c = CNT_W'(r);
    end
    return c;
  endfunction

  assign n_in  = eff_count(in_cfg_q);
  assign n_out = eff_count(out_cfg_q);
  assign kept  = (n_in < n_out) ? n_in : n_out;

  assign full_o    = item_full_i;
  assign accept    = push_i && !item_full_i;
  assign keep_ch   = ((CNT_W + 1)'(pos_q) < (CNT_W + 1)'(kept));
  assign pos_next  = (CNT_W + 1)'(pos_q) + 1'b1;
  assign frame_end = (pos_next == (CNT_W + 1)'(kept));

  // dropped channels never enter the queue
  assign item_push_o = accept && keep_ch;
  assign item_o      = {half_q, frame_end, pos_q, dsd_byte_i};

  // a write to a known register restarts the stream
  always_comb begin
    clear_o = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INPUT_CHANNELS:  clear_o = 1'b1;
        CFG_OUTPUT_CHANNELS: clear_o = 1'b1;
        default:             clear_o = 1'b0;
      endcase
    end
  end

  // position within the interleaved frame
  always_comb begin
    pos_d  = pos_q;
    half_d = half_q;
    if (clear_o) begin
      pos_d  = '0;
      half_d = 1'b0;
    end else if (accept) begin
      if (pos_next >= (CNT_W + 1)'(n_in)) begin
        pos_d  = '0;
        half_d = !half_q;
      end else begin
        pos_d = CH_W'(pos_next);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cfg_q  <= CFG_RESET;
      out_cfg_q <= CFG_RESET;
      pos_q     <= '0;
      half_q    <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      half_q <= half_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_INPUT_CHANNELS:  in_cfg_q  <= cfg_data_i;
          CFG_OUTPUT_CHANNELS: out_cfg_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: rtl/dtdp_back.sv
module dtdp_back
  import dtdp_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  parameter int ITEM_W       = CH_W + BYTE_W + 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  // classified items in
  input  logic [ITEM_W-1:0] item_i,
  input  logic              item_empty_i,
  output logic              item_pop_o,
  // results out
  output logic              res_push_o,
  output dop_result_t       res_o,
  input  logic              res_full_i
);

  logic [BYTE_W-1:0]       held_q [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] phase_q, phase_d;
  logic                    it_half, it_fe;
  logic [CH_W-1:0]         it_ch;
  logic [BYTE_W-1:0]       it_byte;
  logic                    hold_we;

  assign {it_half, it_fe, it_ch, it_byte} = item_i;

  // even-sample bytes are stored, odd-sample bytes need room downstream
  assign hold_we    = !item_empty_i && !it_half;
  assign res_push_o = !item_empty_i && it_half && !res_full_i;
  assign item_pop_o = hold_we || res_push_o;

  // word assembly
  always_comb begin
    res_o.dop_word  = {(phase_q[it_ch] ? MARKER_ODD : MARKER_EVEN), held_q[it_ch], it_byte};
    res_o.channel   = CHAN_OUT_W'(it_ch);
    res_o.frame_end = it_fe;
  end

  // per-channel marker toggle
  always_comb begin
    phase_d = phase_q;
    if (clear_i) begin
      phase_d = '0;
    end else if (res_push_o) begin
      phase_d[it_ch] = !phase_q[it_ch];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  // held bytes, valid once written
  always_ff @(posedge clk_i) begin
    if (hold_we) begin
      held_q[it_ch] <= it_byte;
    end
  end

endmodule

// File: rtl/dsd_to_dop_packer_top.sv
// DSD to DoP packer.
// Input channel: a byte is taken on a rising edge with push high and full low.
// Bytes arrive channel-interleaved: one per input channel of the even DSD
// sample, then one per channel of the odd sample. Output channel: while
// empty is low the oldest DoP word is on dop_word_o/channel_o/frame_end_o;
// it is taken on a rising edge with pop high. Each kept channel yields one
// 24-bit word per even/odd pair, marker 0x05/0xFA alternating per channel.
// Configuration: cfg_we_i writes cfg_data_i into the register at cfg_idx_i
// (0 input channel count, 1 output channel count); write only while idle.
// A write to either register restarts the stream and resets all markers.
// Throughput: one byte per cycle sustained while the receiver keeps up.
// A completing byte passes through the item queue and then the output
// queue before it shows on the output.
// Reset: counts return to 2, stream position and markers are cleared.
// If the receiver stalls, the output queue fills, the assembler stops, the
// middle queue fills, and full rises; even-sample bytes still drain into
// the held-byte store until an odd-sample byte blocks the assembler.
module dsd_to_dop_packer_top
  import dtdp_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  // byte stream
  input  logic                  push,
  output logic                  full,
  input  logic [BYTE_W-1:0]     dsd_byte_i,
  // DoP words
  output logic                  empty,
  input  logic                  pop,
  output logic [WORD_W-1:0]     dop_word_o,
  output logic [CHAN_OUT_W-1:0] channel_o,
  output logic                  frame_end_o
);

  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ITEM_W = CH_W + BYTE_W + 2;
  localparam int RES_W  = $bits(dop_result_t);

  logic              clear;
  logic              item_push, item_full, item_pop, item_empty;
  logic [ITEM_W-1:0] item_in, item_out;
  logic              res_push, res_full;
  dop_result_t       res_in, res_out;

  // front: position tracking and channel classification
  dtdp_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .CH_W         (CH_W),
    .ITEM_W       (ITEM_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .clear_o     (clear),
    .push_i      (push),
    .dsd_byte_i  (dsd_byte_i),
    .full_o      (full),
    .item_push_o (item_push),
    .item_o      (item_in),
    .item_full_i (item_full)
  );

  // queue between front and back
  dtdp_fifo #(
    .WIDTH (ITEM_W)
  ) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (item_push),
    .data_i  (item_in),
    .full_o  (item_full),
    .pop_i   (item_pop),
    .data_o  (item_out),
    .empty_o (item_empty)
  );

  // back: held bytes, markers, word assembly
  dtdp_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .CH_W         (CH_W),
    .ITEM_W       (ITEM_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (clear),
    .item_i       (item_out),
    .item_empty_i (item_empty),
    .item_pop_o   (item_pop),
    .res_push_o   (res_push),
    .res_o        (res_in),
    .res_full_i   (res_full)
  );

  // output queue
  dtdp_fifo #(
    .WIDTH (RES_W)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign dop_word_o  = res_out.dop_word;
  assign channel_o   = res_out.channel;
  assign frame_end_o = res_out.frame_end;

endmodule

// File: sim/tb_top.sv
module tb_top
  import dtdp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET   = 1900;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1000000;

  // Register indexes that the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  // Idle behavior of both sides, picked per phase
  localparam int IDLE_NONE  = 0;
  localparam int IDLE_LIGHT = 1;
  localparam int IDLE_HEAVY = 2;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_W-1:0]      cfg_data_i = '0;
  logic                  push       = 1'b0;
  logic                  full;
  logic [BYTE_W-1:0]     dsd_byte_i = '0;
  logic                  empty;
  logic                  pop        = 1'b0;
  logic [WORD_W-1:0]     dop_word_o;
  logic [CHAN_OUT_W-1:0] channel_o;
  logic                  frame_end_o;

  int idle_mode   = IDLE_NONE;
  int cycle_count = 0;

  // DoP packing predictor plus the queue of words still owed by the block
  class dop_scoreboard;
    logic [CFG_W-1:0]  in_count_reg;
    logic [CFG_W-1:0]  out_count_reg;
    int unsigned       chan_pos;
    bit                odd_half;
    logic [BYTE_W-1:0] held[MAX_CHANNELS_DEF];
    bit                marker_odd[MAX_CHANNELS_DEF];
    dop_result_t       owed_words[$];
    int unsigned       error_count;
    int unsigned       byte_count;

    function new();
      in_count_reg  = CFG_RESET;
      out_count_reg = CFG_RESET;
      error_count   = 0;
      byte_count    = 0;
      clear_stream();
    endfunction

    // 0 acts as 1, anything past the capacity acts as the capacity
    function int unsigned eff_count(logic [CFG_W-1:0] r);
      if (r == 0) return 1;
      if (r > MAX_CHANNELS_DEF) return MAX_CHANNELS_DEF;
      return r;
    endfunction

    function void clear_stream();
      chan_pos = 0;
      odd_half = 1'b0;
      foreach (held[i]) held[i] = '0;
      foreach (marker_odd[i]) marker_odd[i] = 1'b0;
    endfunction

    // unknown indexes leave everything alone
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_INPUT_CHANNELS:  in_count_reg = data;
        CFG_OUTPUT_CHANNELS: out_count_reg = data;
        default: return;
      endcase
      clear_stream();
    endfunction

    function int unsigned owed();
      return owed_words.size();
    endfunction

    // one accepted byte; an odd-sample byte of a kept channel owes a word
    function void note_byte(logic [BYTE_W-1:0] b);
      int unsigned n_in;
      int unsigned n_out;
      int unsigned kept;
      dop_result_t w;
      n_in  = eff_count(in_count_reg);
      n_out = eff_count(out_count_reg);
      kept  = (n_in < n_out) ? n_in : n_out;
      byte_count++;
      if (chan_pos < kept && chan_pos < MAX_CHANNELS_DEF) begin
        if (!odd_half) begin
          held[chan_pos] = b;
        end else begin
          w.dop_word  = {marker_odd[chan_pos] ? MARKER_ODD : MARKER_EVEN, held[chan_pos], b};
          w.channel   = chan_pos[CHAN_OUT_W-1:0];
          w.frame_end = (chan_pos + 1 == kept);
          marker_odd[chan_pos] = ~marker_odd[chan_pos];
          owed_words.push_back(w);
        end
      end
      chan_pos++;
      if (chan_pos >= n_in) begin
        chan_pos = 0;
        odd_half = ~odd_half;
      end
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
    endtask

    task check_word(logic [WORD_W-1:0] word, logic [CHAN_OUT_W-1:0] chan, logic fe);
      dop_result_t exp_w;
      if (owed_words.size() == 0) begin
        report($sformatf("unexpected word %06h ch %0d", word, chan));
        return;
      end
      exp_w = owed_words.pop_front();
      if (word !== exp_w.dop_word)
        report($sformatf("dop_word %06h, want %06h", word, exp_w.dop_word));
      if (chan !== exp_w.channel)
        report($sformatf("channel %0d, want %0d", chan, exp_w.channel));
      if (fe !== exp_w.frame_end)
        report($sformatf("frame_end %0b, want %0b (ch %0d)", fe, exp_w.frame_end,
                         exp_w.channel));
    endtask
  endclass

  dop_scoreboard sb;

  dsd_to_dop_packer_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .dsd_byte_i  (dsd_byte_i),
    .empty       (empty),
    .pop         (pop),
    .dop_word_o  (dop_word_o),
    .channel_o   (channel_o),
    .frame_end_o (frame_end_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // mostly short gaps, in heavy mode now and then a long one
  function automatic int pick_gap(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      IDLE_LIGHT: return (r < 80) ? 0 : $urandom_range(1, 3);
      IDLE_HEAVY: begin
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 30);
      end
      default: return 0;
    endcase
  endfunction

  // channel count register value, weighted toward the edges
  function automatic logic [CFG_W-1:0] pick_count_reg();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 24) return 4'hF;
    if (r < 34) return CFG_W'($urandom_range(9, 14));
    if (r < 44) return 4'd1;
    if (r < 54) return 4'd8;
    return CFG_W'($urandom_range(1, 8));
  endfunction

  // result side: random pop stalls
  initial begin
    int stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        stall = pick_gap(idle_mode);
      end
    end
  end

  // check every word transaction
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty)
      sb.check_word(dop_word_o, channel_o, frame_end_o);
  end

  // one byte transaction, entered and left on a falling edge
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = pick_gap(idle_mode);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push       <= 1'b1;
    dsd_byte_i <= b;
    do @(posedge clk_i); while (full);
    sb.note_byte(b);
    @(negedge clk_i);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // drain owed words, then let held even-sample bytes settle in the pipe
  task automatic wait_idle();
    push <= 1'b0;
    while (sb.owed() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int frames;
    int n_in;
    sb = new();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset config, two channels: byte extremes, markers 0x05 then 0xFA
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'h3C);
    send_byte(8'hC3);

    // four input channels into two outputs: upper two dropped
    wait_idle();
    cfg_write(CFG_INPUT_CHANNELS, 4'd4);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(8'h44);
    send_byte(8'h55);
    send_byte(8'h66);
    send_byte(8'h77);
    send_byte(8'h88);

    // undecoded index must not restart the stream
    wait_idle();
    cfg_write(CFG_IDX_SPARE_LO, 4'hF);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'hFE);
    send_byte(8'h7F);
    send_byte(8'h40);
    send_byte(8'h02);
    send_byte(8'hBF);
    send_byte(8'hFD);

    // random phases: new settings, whole frames, sometimes a broken tail
    while (sb.byte_count < ITEM_TARGET) begin
      wait_idle();
      idle_mode = $urandom_range(IDLE_NONE, IDLE_HEAVY);
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 1)) begin
          cfg_write(CFG_INPUT_CHANNELS, pick_count_reg());
          cfg_write(CFG_OUTPUT_CHANNELS, pick_count_reg());
        end else begin
          cfg_write(CFG_OUTPUT_CHANNELS, pick_count_reg());
          cfg_write(CFG_INPUT_CHANNELS, pick_count_reg());
        end
      end
      if ($urandom_range(0, 7) == 0)
        cfg_write($urandom_range(0, 1) ? CFG_IDX_SPARE_LO : CFG_IDX_SPARE_HI,
                  CFG_W'($urandom_range(0, 15)));
      n_in   = sb.eff_count(sb.in_count_reg);
      frames = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      send_random(frames * 2 * n_in);
      if ($urandom_range(0, 3) == 0)
        send_random($urandom_range(1, 2 * n_in));
    end

    // wind down
    wait_idle();
    if (sb.error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: dsd_to_dop_packer_top.f
rtl/dtdp_pkg.sv
rtl/dtdp_fifo.sv
rtl/dtdp_front.sv
rtl/dtdp_back.sv
rtl/dsd_to_dop_packer_top.sv
sim/tb_top.sv
